// ===== rtl/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// shared types, constants and the cordic arctangent table for the odometry
// ----------------------------------------------------------------------------
package odo_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QMUL,
        ST_AMUL,
        ST_TLMUL,
        ST_TRMUL,
        ST_DCMUL,
        ST_ROT,
        ST_XMUL,
        ST_YMUL,
        ST_DONE
    } t_state;

    // request to the bit-serial multiplier
    typedef struct packed {
        logic       start;
        logic       neg_last;   // multiplier is two's complement
        logic [6:0] steps;      // multiplier bits to consume
    } t_mul_req;

    localparam logic [23:0] DPT_RESET  = 24'd428246;
    localparam logic [23:0] IWB_RESET  = 24'd218453;
    localparam logic [29:0] RAD_TO_BAM = 30'd683565276;
    localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

    localparam logic [6:0] STEPS_Q  = 7'd24;
    localparam logic [6:0] STEPS_A  = 7'd30;
    localparam logic [6:0] STEPS_T  = 7'd32;
    localparam logic [6:0] STEPS_DC = 7'd24;
    localparam logic [6:0] STEPS_MV = 7'd34;

    localparam logic ADDR_DPT = 1'b0;
    localparam logic ADDR_IWB = 1'b1;

    function automatic logic [31:0] atan_bam(input logic [4:0] k);
        logic [31:0] v;
        v = 32'd0;
        case (k)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/odo_mul.sv =====
// ----------------------------------------------------------------------------
// odo_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle, lsb first
// ----------------------------------------------------------------------------
module odo_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  odo_pkg::t_mul_req  i_req,
    input  logic [63:0]        i_mcand,   // signed multiplicand
    input  logic [63:0]        i_mult,    // multiplier, consumed from bit 0
    output logic               o_done,
    output logic [64:0]        o_acc,     // product high part
    output logic [63:0]        o_lo       // product low bits, top aligned
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic        r_neg;
    logic [63:0] r_mcand;
    logic [63:0] r_mult;
    logic [64:0] r_acc;
    logic [63:0] r_lo;

    logic [65:0] addend;
    logic [65:0] sum;

    always_comb begin
        addend = 66'd0;
        if (r_mult[0]) begin
            if (r_neg && (r_cnt == 7'd1)) begin
                addend = 66'd0 - {{2{r_mcand[63]}}, r_mcand};
            end else begin
                addend = {{2{r_mcand[63]}}, r_mcand};
            end
        end
        sum = {r_acc[64], r_acc} + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg   <= i_req.neg_last;
            r_mcand <= i_mcand;
            r_mult  <= i_mult;
            r_acc   <= 65'd0;
            r_lo    <= 64'd0;
        end else if (r_busy) begin
            r_acc  <= sum[65:1];
            r_lo   <= {sum[0], r_lo[63:1]};
            r_mult <= {1'b0, r_mult[63:1]};
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_lo   = r_lo;

endmodule

// ===== rtl/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// odo_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle, q30 outputs
// ----------------------------------------------------------------------------
module odo_cordic #(
    parameter int STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_angle,
    output logic        o_done,
    output logic [33:0] o_cos,
    output logic [33:0] o_sin
);

    localparam int CW = $clog2(STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_i;
    logic          r_flip;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [32:0] r_z;

    logic signed [32:0] z_in;
    logic signed [32:0] z_pre;
    logic               flip_pre;
    logic [4:0]         k;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [32:0] at;

    always_comb begin
        z_in     = {i_angle[31], i_angle};
        z_pre    = z_in;
        flip_pre = 1'b0;
        // fold angles beyond a quarter turn by a half turn
        if (z_in > 33'sd1073741824) begin
            z_pre    = z_in - 33'sd2147483648;
            flip_pre = 1'b1;
        end else if (z_in < -33'sd1073741824) begin
            z_pre    = z_in + 33'sd2147483648;
            flip_pre = 1'b1;
        end
        k  = 5'(r_i);
        xs = r_x >>> k;
        ys = r_y >>> k;
        at = {1'b0, odo_pkg::atan_bam(k)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_i == CW'(STEPS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_flip <= flip_pre;
            r_x    <= signed'(odo_pkg::CORDIC_GAIN_Q30);
            r_y    <= 34'sd0;
            r_z    <= z_pre;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (!r_z[32]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? (34'd0 - r_x) : r_x;
    assign o_sin  = r_flip ? (34'd0 - r_y) : r_y;

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry
// fixed-point dead reckoning for a two-wheel robot from absolute encoder counts
// ----------------------------------------------------------------------------
// the first sample after reset only stores its counts and goes straight to the
//   done state; later samples run seven bit-serial products (one multiplier bit per
//   cycle) and the cordic. One item at a time: the next is accepted only once the
//   result of the current one has entered the output register
// reset: synchronous active low; pose, stored counts and sample flag clear,
//   registers return to their defaults, no result pending
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [31:0] left_count, [63:32] right_count
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] heading_angle
    output logic [1:0]   m_axis_tuser,   // [0] pose_updated, [1] position_saturated
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // configuration registers
    logic [23:0] r_dpt;
    logic [23:0] r_iwb;

    // control
    odo_pkg::t_state r_state, n_state;
    logic            r_go;         // operation issued in the current state
    logic            r_have_last;

    // odometry state
    logic [31:0] r_last_l;
    logic [31:0] r_last_r;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_heading;

    // per-item intermediates
    logic [31:0] r_dl;
    logic [31:0] r_dr;
    logic [32:0] r_dsum;
    logic [47:0] r_q;          // radians per tick, 2^-48
    logic [61:0] r_a;          // turn per tick, 2^-64 turn
    logic [31:0] r_tl;
    logic [55:0] r_dc;         // centre travel, 2^-32 m
    logic        r_upd;
    logic        r_sat;

    // output register
    logic        r_ovalid;
    logic [95:0] r_odata;
    logic [1:0]  r_ouser;

    // multiplier
    odo_pkg::t_mul_req mul_req;
    logic [63:0]       mul_mcand;
    logic [63:0]       mul_mult;
    logic              mul_done;
    logic [64:0]       mul_acc;
    logic [63:0]       mul_lo;

    // cordic
    logic        cor_start;
    logic        cor_done;
    logic [33:0] cor_cos;
    logic [33:0] cor_sin;

    logic        in_acc;
    logic        out_acc;
    logic        cfg_wr;
    logic [31:0] in_left;
    logic [31:0] in_right;
    logic [31:0] dl_in;
    logic [31:0] dr_in;
    logic [44:0] move;
    logic [45:0] pos_sum;
    logic [31:0] pos_clip;
    logic        pos_ovf;
    logic        in_mul_state;

    assign in_left  = s_axis_tdata[31:0];
    assign in_right = s_axis_tdata[63:32];
    assign dl_in    = in_left - r_last_l;
    assign dr_in    = in_right - r_last_r;

    assign s_axis_tready = (r_state == odo_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = r_ovalid && m_axis_tready;

    // apb: only address bit 2 selects, so every address lands on a register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == odo_pkg::ADDR_IWB) ? {8'd0, r_iwb} : {8'd0, r_dpt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpt <= odo_pkg::DPT_RESET;
            r_iwb <= odo_pkg::IWB_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == odo_pkg::ADDR_IWB) begin
                r_iwb <= pwdata[23:0];
            end else begin
                r_dpt <= pwdata[23:0];
            end
        end
    end

    // operand selection for the shared serial multiplier
    always_comb begin
        mul_mcand     = 64'd0;
        mul_mult      = 64'd0;
        mul_req.steps = odo_pkg::STEPS_Q;
        mul_req.neg_last = 1'b0;
        in_mul_state  = 1'b1;
        unique case (r_state)
            odo_pkg::ST_QMUL: begin
                mul_mcand = {40'd0, r_dpt};
                mul_mult  = {40'd0, r_iwb};
            end
            odo_pkg::ST_AMUL: begin
                mul_mcand     = {16'd0, r_q};
                mul_mult      = {34'd0, odo_pkg::RAD_TO_BAM};
                mul_req.steps = odo_pkg::STEPS_A;
            end
            odo_pkg::ST_TLMUL: begin
                mul_mcand        = {2'd0, r_a};
                mul_mult         = {32'd0, r_dl};
                mul_req.steps    = odo_pkg::STEPS_T;
                mul_req.neg_last = 1'b1;
            end
            odo_pkg::ST_TRMUL: begin
                mul_mcand        = {2'd0, r_a};
                mul_mult         = {32'd0, r_dr};
                mul_req.steps    = odo_pkg::STEPS_T;
                mul_req.neg_last = 1'b1;
            end
            odo_pkg::ST_DCMUL: begin
                mul_mcand     = {{31{r_dsum[32]}}, r_dsum};
                mul_mult      = {40'd0, r_dpt};
                mul_req.steps = odo_pkg::STEPS_DC;
            end
            odo_pkg::ST_XMUL: begin
                mul_mcand        = {{8{r_dc[55]}}, r_dc};
                mul_mult         = {30'd0, cor_cos};
                mul_req.steps    = odo_pkg::STEPS_MV;
                mul_req.neg_last = 1'b1;
            end
            odo_pkg::ST_YMUL: begin
                mul_mcand        = {{8{r_dc[55]}}, r_dc};
                mul_mult         = {30'd0, cor_sin};
                mul_req.steps    = odo_pkg::STEPS_MV;
                mul_req.neg_last = 1'b1;
            end
            default: begin
                in_mul_state = 1'b0;
            end
        endcase
        mul_req.start = in_mul_state && !r_go;
    end

    assign cor_start = (r_state == odo_pkg::ST_ROT) && !r_go;

    // position step: floor(dc * trig / 2^46), added and clipped to 32 bits
    always_comb begin
        move    = mul_acc[56:12];
        pos_sum = (r_state == odo_pkg::ST_XMUL) ? {{14{r_x[31]}}, r_x}
                                                : {{14{r_y[31]}}, r_y};
        pos_sum = pos_sum + {move[44], move};
        pos_ovf = 1'b0;
        pos_clip = pos_sum[31:0];
        if (!pos_sum[45] && (pos_sum[44:31] != 14'd0)) begin
            pos_clip = 32'h7fffffff;
            pos_ovf  = 1'b1;
        end else if (pos_sum[45] && (pos_sum[44:31] != 14'h3fff)) begin
            pos_clip = 32'h80000000;
            pos_ovf  = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            odo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = r_have_last ? odo_pkg::ST_QMUL : odo_pkg::ST_DONE;
                end
            end
            odo_pkg::ST_QMUL:  if (mul_done) n_state = odo_pkg::ST_AMUL;
            odo_pkg::ST_AMUL:  if (mul_done) n_state = odo_pkg::ST_TLMUL;
            odo_pkg::ST_TLMUL: if (mul_done) n_state = odo_pkg::ST_TRMUL;
            odo_pkg::ST_TRMUL: if (mul_done) n_state = odo_pkg::ST_DCMUL;
            odo_pkg::ST_DCMUL: if (mul_done) n_state = odo_pkg::ST_ROT;
            odo_pkg::ST_ROT:   if (cor_done) n_state = odo_pkg::ST_XMUL;
            odo_pkg::ST_XMUL:  if (mul_done) n_state = odo_pkg::ST_YMUL;
            odo_pkg::ST_YMUL:  if (mul_done) n_state = odo_pkg::ST_DONE;
            odo_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!r_ovalid || m_axis_tready) n_state = odo_pkg::ST_IDLE;
            end
            default: n_state = odo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= odo_pkg::ST_IDLE;
            r_go        <= 1'b0;
            r_have_last <= 1'b0;
            r_last_l    <= 32'd0;
            r_last_r    <= 32'd0;
            r_x         <= 32'd0;
            r_y         <= 32'd0;
            r_heading   <= 32'd0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_go <= 1'b0;
            end else if (mul_req.start || cor_start) begin
                r_go <= 1'b1;
            end

            if (in_acc) begin
                r_last_l    <= in_left;
                r_last_r    <= in_right;
                r_have_last <= 1'b1;
            end

            if ((r_state == odo_pkg::ST_TRMUL) && mul_done) begin
                r_heading <= r_heading + mul_acc[31:0] - r_tl;
            end
            if ((r_state == odo_pkg::ST_XMUL) && mul_done) begin
                r_x <= pos_clip;
            end
            if ((r_state == odo_pkg::ST_YMUL) && mul_done) begin
                r_y <= pos_clip;
            end

            if ((r_state == odo_pkg::ST_DONE) && (n_state == odo_pkg::ST_IDLE)) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dl   <= dl_in;
            r_dr   <= dr_in;
            r_dsum <= {dl_in[31], dl_in} + {dr_in[31], dr_in};
            r_upd  <= r_have_last;
            r_sat  <= 1'b0;
        end
        if (mul_done) begin
            unique case (r_state)
                odo_pkg::ST_QMUL:  r_q  <= {mul_acc[23:0], mul_lo[63:40]};
                odo_pkg::ST_AMUL:  r_a  <= {mul_acc[47:0], mul_lo[63:50]};
                odo_pkg::ST_TLMUL: r_tl <= mul_acc[31:0];
                odo_pkg::ST_DCMUL: r_dc <= {mul_acc[32:0], mul_lo[63:41]};
                odo_pkg::ST_XMUL,
                odo_pkg::ST_YMUL:  r_sat <= r_sat | pos_ovf;
                default: ;
            endcase
        end
        if ((r_state == odo_pkg::ST_DONE) && (n_state == odo_pkg::ST_IDLE)) begin
            r_odata <= {r_heading, r_y, r_x};
            r_ouser <= {r_sat, r_upd};
        end
    end

    odo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_mcand (mul_mcand),
        .i_mult  (mul_mult),
        .o_done  (mul_done),
        .o_acc   (mul_acc),
        .o_lo    (mul_lo)
    );

    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (r_heading),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

// ===== rtl/odo_checker.sv =====
// ----------------------------------------------------------------------------
// odo_checker
// port-level checks for the odometry block, bound to the top level
// ----------------------------------------------------------------------------
module odo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        pready
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // saturation is only reported on an updated pose
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("saturation without pose update");

    // one item at a time: no second item right after an accept
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while busy");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && pready)
        else $error("bad state after reset");

endmodule

bind differential_drive_odometry odo_checker u_odo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);
